@@ rtl/bptb_pkg.sv @@
// Shared definitions for the bracket pair table builder.
// Holds symbol codes, event and error codes, and stack control structs.
// Depends on nothing; the top level and bptb_stack use it.
package bptb_pkg;

  localparam int MaxLenDefault = 4096;

  localparam logic [7:0] SymRoundOpen   = 8'h28;
  localparam logic [7:0] SymRoundClose  = 8'h29;
  localparam logic [7:0] SymSquareOpen  = 8'h5B;
  localparam logic [7:0] SymSquareClose = 8'h5D;

  typedef enum logic [1:0] {
    EvUnpaired = 2'd0,
    EvPushed   = 2'd1,
    EvClosed   = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ErNone        = 3'd0,
    ErStrayRound  = 3'd1,
    ErStraySquare = 3'd2,
    ErOpenRound   = 3'd3,
    ErOpenSquare  = 3'd4,
    ErAborted     = 3'd5,
    ErTooLong     = 3'd6
  } error_e;

  // Operation on one position stack for the current cycle.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_cmd_t;

  // Occupancy of one position stack before the current operation.
  typedef struct packed {
    logic empty;
    logic single;
  } stack_stat_t;

endpackage

@@ rtl/bracket_pair_table_builder_top.sv @@
// Bracket pair table builder: top level with the matcher control and output buffer.
// Depends on bptb_pkg, bptb_stack and bptb_obuf.
//
// This block reads a dot-bracket structure one character per request and
// returns one result request per character: its one-based position, the
// partner position when a close completes a pair, an event code and an error
// code, with tlast copied from the input. Round and square brackets each have
// their own position stack held in a synchronous memory of MaxLen entries;
// square brackets are paired only while the square_enable register is set.
// The block takes one character every clock cycle for as long as results are
// taken, and a result is registered straight into the output register when
// its character is accepted while that register is free. The rate is set by
// the stack memories: each character does at most one push or one pop, and
// the next top of stack is prefetched, with a push of the previous
// cycle forwarded from a register, so back-to-back pops and pushes never
// wait. Two results can be held at the output, so the slave side keeps
// accepting while one result waits to be taken; it stalls only while both
// are held. The stacks need no clearing pass after reset; only their depth
// counters and forward flags are reset. A close on an empty stack, a
// structure longer than MaxLen, or a stack still open at the last character
// flags an error, and after a stray close or an overlong structure every later
// character of that structure reports aborted.
module bracket_pair_table_builder_top #(
  parameter int  MaxLen = bptb_pkg::MaxLenDefault,
  localparam int PosW   = $clog2(MaxLen + 2),
  localparam int DataW  = ((2 * PosW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: square_enable.
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  // Character requests.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] symbol
  input  logic             s_axis_tlast_i,   // last_symbol
  // Result requests.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,   // position, then partner, zero fill above
  output logic [4:0]       m_axis_tuser_o,   // [1:0] event_res, [4:2] error
  output logic             m_axis_tlast_o    // done_res
);

  localparam int ResW = DataW + 5 + 1;
  localparam logic [PosW-1:0] MaxLenP = PosW'(MaxLen);

  logic                  accept;
  logic                  ob_ready;
  logic [PosW-1:0]       char_pos_q, char_pos_d;
  logic                  aborted_q, aborted_d;
  logic                  sq_en_q;
  logic [PosW-1:0]       pos_calc;
  logic [PosW-1:0]       partner;
  bptb_pkg::event_e      ev;
  bptb_pkg::error_e      err;
  logic                  abort_set;
  logic                  rnd_nonempty_after, sqr_nonempty_after;
  bptb_pkg::stack_cmd_t  rnd_req, sqr_req;
  bptb_pkg::stack_cmd_t  rnd_cmd, sqr_cmd;
  bptb_pkg::stack_stat_t rnd_stat, sqr_stat;
  logic [PosW-1:0]       rnd_top, sqr_top;
  logic [ResW-1:0]       res_in, res_out;
  logic [DataW-1:0]      res_data;

  assign accept          = s_axis_tvalid_i && ob_ready;
  assign s_axis_tready_o = ob_ready;

  // Position saturates one past the maximum length.
  assign pos_calc = (char_pos_q <= MaxLenP) ? char_pos_q + PosW'(1) : char_pos_q;

  // Character decode with the stack checks done before any pop.
  always_comb begin
    rnd_req   = '0;
    sqr_req   = '0;
    ev        = bptb_pkg::EvUnpaired;
    err       = bptb_pkg::ErNone;
    partner   = '0;
    abort_set = 1'b0;
    if (aborted_q) begin
      err = bptb_pkg::ErAborted;
    end else if (pos_calc > MaxLenP) begin
      err       = bptb_pkg::ErTooLong;
      abort_set = 1'b1;
    end else if (s_axis_tdata_i == bptb_pkg::SymRoundOpen) begin
      rnd_req.push = 1'b1;
      ev           = bptb_pkg::EvPushed;
    end else if (s_axis_tdata_i == bptb_pkg::SymRoundClose) begin
      if (!rnd_stat.empty) begin
        rnd_req.pop = 1'b1;
        ev          = bptb_pkg::EvClosed;
        partner     = rnd_top;
      end else begin
        err       = bptb_pkg::ErStrayRound;
        abort_set = 1'b1;
      end
    end else if (sq_en_q && (s_axis_tdata_i == bptb_pkg::SymSquareOpen)) begin
      sqr_req.push = 1'b1;
      ev           = bptb_pkg::EvPushed;
    end else if (sq_en_q && (s_axis_tdata_i == bptb_pkg::SymSquareClose)) begin
      if (!sqr_stat.empty) begin
        sqr_req.pop = 1'b1;
        ev          = bptb_pkg::EvClosed;
        partner     = sqr_top;
      end else begin
        err       = bptb_pkg::ErStraySquare;
        abort_set = 1'b1;
      end
    end

    // Open-at-end check looks at the depths after this character's operation.
    rnd_nonempty_after = rnd_req.push ||
                         (!rnd_stat.empty && !(rnd_req.pop && rnd_stat.single));
    sqr_nonempty_after = sqr_req.push ||
                         (!sqr_stat.empty && !(sqr_req.pop && sqr_stat.single));
    if (s_axis_tlast_i && (err == bptb_pkg::ErNone)) begin
      if (rnd_nonempty_after) begin
        err = bptb_pkg::ErOpenRound;
      end else if (sqr_nonempty_after) begin
        err = bptb_pkg::ErOpenSquare;
      end
    end
  end

  // Stack operations only take effect for an accepted character.
  always_comb begin
    rnd_cmd.push  = accept && rnd_req.push;
    rnd_cmd.pop   = accept && rnd_req.pop;
    rnd_cmd.clear = accept && s_axis_tlast_i;
    sqr_cmd.push  = accept && sqr_req.push;
    sqr_cmd.pop   = accept && sqr_req.pop;
    sqr_cmd.clear = accept && s_axis_tlast_i;
  end

  always_comb begin
    char_pos_d = char_pos_q;
    aborted_d  = aborted_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        char_pos_d = '0;
        aborted_d  = 1'b0;
      end else begin
        char_pos_d = pos_calc;
        aborted_d  = aborted_q || abort_set;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q <= '0;
      aborted_q  <= 1'b0;
      sq_en_q    <= 1'b1;
    end else begin
      char_pos_q <= char_pos_d;
      aborted_q  <= aborted_d;
      if (cfg_we_i) begin
        sq_en_q <= cfg_wdata_i;
      end
    end
  end

  bptb_stack #(
    .MaxLen (MaxLen),
    .W      (PosW)
  ) u_round_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (rnd_cmd),
    .push_data_i (pos_calc),
    .top_o       (rnd_top),
    .stat_o      (rnd_stat)
  );

  bptb_stack #(
    .MaxLen (MaxLen),
    .W      (PosW)
  ) u_square_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (sqr_cmd),
    .push_data_i (pos_calc),
    .top_o       (sqr_top),
    .stat_o      (sqr_stat)
  );

  assign res_data = DataW'({partner, pos_calc});
  assign res_in   = {s_axis_tlast_i, err, ev, res_data};

  bptb_obuf #(
    .W (ResW)
  ) u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (ob_ready),
    .in_data_i   (res_in),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata_o = res_out[DataW-1:0];
  assign m_axis_tuser_o = res_out[DataW+4:DataW];
  assign m_axis_tlast_o = res_out[ResW-1];

  // The slave side only stalls when both output entries are full.
  a_stall_means_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result held at the output");

  // A pop is never issued against an empty stack.
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((rnd_cmd.pop && rnd_stat.empty) || (sqr_cmd.pop && sqr_stat.empty)))
    else $error("pop issued on an empty stack");

  // An aborted structure stays aborted until its last character is accepted.
  a_abort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (aborted_q && !(accept && s_axis_tlast_i)) |=> aborted_q)
    else $error("aborted flag dropped inside a structure");

  // The position counter saturates one past the maximum length.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_pos_q <= MaxLenP + PosW'(1))
    else $error("character position beyond saturation value");

endmodule

@@ rtl/bptb_stack.sv @@
// One position stack kept in a synchronous memory with a registered read.
// The top entry is prefetched every cycle; a push in the previous cycle is forwarded.
// Depends on bptb_pkg.
module bptb_stack #(
  parameter int MaxLen = bptb_pkg::MaxLenDefault,
  parameter int W      = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bptb_pkg::stack_cmd_t cmd_i,
  input  logic [W-1:0]         push_data_i,
  output logic [W-1:0]         top_o,
  output bptb_pkg::stack_stat_t stat_o
);

  localparam int AW = $clog2(MaxLen);
  localparam int CW = $clog2(MaxLen + 1);

  logic [W-1:0]  stack_mem [MaxLen];
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  rdata_q;
  logic [W-1:0]  fwd_q;
  logic          fwd_sel_q, fwd_sel_d;
  logic          push_ok;
  logic          pop_ok;

  assign push_ok = cmd_i.push && (count_q < CW'(MaxLen));
  assign pop_ok  = cmd_i.pop && (count_q != '0);
  assign waddr   = count_q[AW-1:0];

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (push_ok) begin
      count_d = count_q + CW'(1);
    end else if (pop_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  // Prefetch the entry that will be on top after this cycle's operation.
  always_comb begin
    if (count_d == '0) begin
      raddr = '0;
    end else begin
      raddr = AW'(count_d - CW'(1));
    end
  end

  // A push lands in memory at this edge, so its value is served from fwd_q.
  assign fwd_sel_d = push_ok;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      stack_mem[waddr] <= push_data_i;
    end
    rdata_q <= stack_mem[raddr];
    fwd_q   <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      fwd_sel_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      fwd_sel_q <= fwd_sel_d;
    end
  end

  assign top_o         = fwd_sel_q ? fwd_q : rdata_q;
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.single = (count_q == CW'(1));

endmodule

@@ rtl/bptb_obuf.sv @@
// Two-entry output buffer: an output register plus a skid register.
// Lets the producer hand over a request while a finished one still waits.
// Depends on nothing beyond its parameter.
module bptb_obuf #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic [W-1:0] main_q, skid_q;
  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  logic         load_main_in, load_main_skid, load_skid;
  logic         in_fire, out_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d   = main_valid_q;
    skid_valid_d   = skid_valid_q;
    load_main_in   = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    if (skid_valid_q) begin
      if (out_fire) begin
        load_main_skid = 1'b1;
        skid_valid_d   = 1'b0;
      end
    end else if (in_fire) begin
      if (!main_valid_q || out_fire) begin
        load_main_in = 1'b1;
        main_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main_in) begin
      main_q <= in_data_i;
    end else if (load_main_skid) begin
      main_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

endmodule
